>>> rtl/lz77te_pkg.sv
// Shared types and field widths for the LZ77 triple encoder.
`timescale 1ns / 1ps

package lz77te_pkg;

	localparam int BYTE_W = 8;
	localparam int OFF_W  = 6;
	localparam int LEN_W  = 4;

	typedef logic [BYTE_W-1:0] byte_t;

	// Broadcast control to every cell of the window row.
	typedef struct packed {
		logic load;   // copy window byte into probe, arm the match flag
		logic step;   // compare probe with reference, shift probe left
		logic slide;  // shift window byte left
	} cell_ctl_t;

endpackage

>>> rtl/lz77te_cell.sv
// One window position: window byte, shifting probe byte and match flag.
`timescale 1ns / 1ps

module lz77te_cell import lz77te_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cell_ctl_t ctl,
	input  logic      wr_en,
	input  byte_t     wr_data,
	input  byte_t     win_right,
	input  byte_t     probe_right,
	input  byte_t     ref_byte,
	output byte_t     win,
	output byte_t     probe,
	output logic      alive
);

	byte_t win_q;
	byte_t probe_q;
	logic  alive_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			win_q <= wr_data;
		end else if (ctl.slide) begin
			win_q <= win_right;
		end
		if (ctl.load) begin
			probe_q <= win_q;
		end else if (ctl.step) begin
			probe_q <= probe_right;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alive_q <= 1'b0;
		end else if (ctl.load) begin
			alive_q <= 1'b1;
		end else if (ctl.step) begin
			alive_q <= alive_q & (probe_q == ref_byte);
		end
	end

	assign win   = win_q;
	assign probe = probe_q;
	assign alive = alive_q;

endmodule

>>> rtl/lz77te_ffs.sv
// Registered binary tree that finds the lowest set bit of a vector.
`timescale 1ns / 1ps

module lz77te_ffs #(
	parameter int N = 32
) (
	input  logic                 clk,
	input  logic [N-1:0]         leaves,
	output logic                 found,
	output logic [$clog2(N)-1:0] index
);

	localparam int LG = $clog2(N);
	localparam int P2 = 1 << LG;

	logic          node_v [1:2*P2-1];
	logic [LG-1:0] node_i [1:2*P2-1];
	logic          nv_q   [1:P2-1];
	logic [LG-1:0] ni_q   [1:P2-1];

	always_comb begin
		for (int i = 1; i < P2; i++) begin
			node_v[i] = nv_q[i];
			node_i[i] = ni_q[i];
		end
		for (int i = P2; i < 2*P2; i++) begin
			node_i[i] = LG'(i - P2);
			if (i - P2 < N) begin
				node_v[i] = leaves[i - P2];
			end else begin
				node_v[i] = 1'b0;
			end
		end
	end

	// Each node takes its left child when that one has a hit, else its right.
	always_ff @(posedge clk) begin
		for (int i = 1; i < P2; i++) begin
			nv_q[i] <= node_v[2*i] | node_v[2*i+1];
			ni_q[i] <= node_v[2*i] ? node_i[2*i] : node_i[2*i+1];
		end
	end

	assign found = nv_q[1];
	assign index = ni_q[1];

endmodule

>>> rtl/lz77_triple_encoder.sv
// Top level of the streaming LZ77 triple encoder.
`timescale 1ns / 1ps

// Streaming LZ77 encoder. The first SEARCH_SIZE bytes of a stream come back
// as literal tokens and prime the search window; later bytes collect in the
// lookahead, and once it holds LOOKAHEAD_SIZE bytes (or the last byte has
// arrived, in which case it drains fully) the block emits (offset, length,
// next byte) triples, longest match first-start-wins, and slides the window
// by length+1. The row of cells walks the lookahead one byte a cycle, the
// lowest matching start is found by a registered tree of clog2(SEARCH_SIZE)
// levels, and the window then slides one byte a cycle. One request is in
// work at a time; a new byte is taken while a finished token still waits at
// the output. The window needs no clearing after reset: priming writes it
// before use.
module lz77_triple_encoder import lz77te_pkg::*; #(
	parameter int SEARCH_SIZE    = 32,
	parameter int LOOKAHEAD_SIZE = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             data_valid,
	output logic             data_ready,
	input  logic [7:0]       data_byte,
	input  logic             is_last,
	output logic             token_valid,
	input  logic             token_ready,
	output logic             is_literal,
	output logic [OFF_W-1:0] match_offset,
	output logic [LEN_W-1:0] match_length,
	output logic [7:0]       next_char,
	output logic             final_token
);

	localparam int S  = SEARCH_SIZE;
	localparam int L  = LOOKAHEAD_SIZE;
	localparam int NC = S + L;
	localparam int AW = $clog2(NC);
	localparam int PW = $clog2(S + 1);
	localparam int FW = $clog2(L + 1);
	localparam int LW = $clog2(L);
	localparam int LG = $clog2(S);
	localparam int OW = $clog2(S + 1);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_PUSH  = 3'd1;
	localparam logic [2:0] ST_START = 3'd2;
	localparam logic [2:0] ST_CMP   = 3'd3;
	localparam logic [2:0] ST_SLIDE = 3'd4;

	logic [2:0]    state_q;
	logic [PW-1:0] primed_q;
	logic [FW-1:0] fill_q;
	logic          last_q;
	logic [LW-1:0] cap_q;
	logic [LW-1:0] step_q;
	logic [LW-1:0] best_q;
	logic [LG-1:0] start_q;
	logic [LW-1:0] slide_q;
	logic          tag_v_q [0:LG];
	logic [LW-1:0] tag_q   [0:LG];

	// pending token, moved to the output register when that frees up
	logic             tok_lit_q;
	logic [OFF_W-1:0] tok_off_q;
	logic [LEN_W-1:0] tok_len_q;
	byte_t            tok_char_q;
	logic             tok_fin_q;
	logic             out_valid_q;

	logic          accept;
	logic          priming;
	logic          out_free;
	logic          tags_busy;
	logic          do_step;
	logic [AW-1:0] wr_idx;
	logic [FW-1:0] fill_inc;
	logic [FW-1:0] fill_rem;
	logic [OW-1:0] off_full;
	cell_ctl_t     ctl;

	byte_t         win_w   [NC];
	byte_t         probe_w [NC];
	logic [S-1:0]  alive_w;
	logic          hit;
	logic [LG-1:0] hit_idx;

	assign data_ready = (state_q == ST_IDLE);
	assign accept     = data_valid && data_ready;
	assign priming    = (primed_q < PW'(S));
	assign out_free   = !out_valid_q || token_ready;
	assign do_step    = (state_q == ST_CMP) && (step_q < cap_q);
	assign fill_inc   = fill_q + FW'(1);
	assign fill_rem   = fill_q - FW'(best_q) - FW'(1);
	assign off_full   = OW'(S) - OW'(start_q);
	assign wr_idx     = priming ? AW'(primed_q) : AW'(S) + AW'(fill_q);

	always_comb begin
		tags_busy = 1'b0;
		for (int i = 0; i <= LG; i++) begin
			tags_busy = tags_busy | tag_v_q[i];
		end
	end

	always_comb begin
		ctl.load  = (state_q == ST_START);
		ctl.step  = do_step;
		ctl.slide = (state_q == ST_SLIDE);
	end

	// Row of window cells; cell S carries the lookahead reference byte.
	for (genvar g = 0; g < NC; g++) begin : g_cell
		byte_t win_r;
		byte_t probe_r;
		if (g < NC - 1) begin : g_mid
			assign win_r   = win_w[g+1];
			assign probe_r = probe_w[g+1];
		end else begin : g_end
			assign win_r   = '0;
			assign probe_r = '0;
		end
		if (g < S) begin : g_search
			lz77te_cell u_cell (
				.clk         (clk),
				.arst_n      (arst_n),
				.ctl         (ctl),
				.wr_en       (accept && (wr_idx == AW'(g))),
				.wr_data     (data_byte),
				.win_right   (win_r),
				.probe_right (probe_r),
				.ref_byte    (probe_w[S]),
				.win         (win_w[g]),
				.probe       (probe_w[g]),
				.alive       (alive_w[g])
			);
		end else begin : g_look
			lz77te_cell u_cell (
				.clk         (clk),
				.arst_n      (arst_n),
				.ctl         (ctl),
				.wr_en       (accept && (wr_idx == AW'(g))),
				.wr_data     (data_byte),
				.win_right   (win_r),
				.probe_right (probe_r),
				.ref_byte    (probe_w[S]),
				.win         (win_w[g]),
				.probe       (probe_w[g]),
				.alive       ()
			);
		end
	end

	lz77te_ffs #(.N(S)) u_ffs (
		.clk    (clk),
		.leaves (alive_w),
		.found  (hit),
		.index  (hit_idx)
	);

	// Step tags follow the match flags through the tree, so each root result
	// is paired with the match length it stands for.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= LG; i++) begin
				tag_v_q[i] <= 1'b0;
			end
		end else begin
			tag_v_q[0] <= do_step;
			for (int i = 1; i <= LG; i++) begin
				tag_v_q[i] <= tag_v_q[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		tag_q[0] <= step_q + LW'(1);
		for (int i = 1; i <= LG; i++) begin
			tag_q[i] <= tag_q[i-1];
		end
	end

	// Main sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			primed_q <= '0;
			fill_q   <= '0;
			last_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (priming) begin
							primed_q <= is_last ? '0 : primed_q + PW'(1);
							state_q  <= ST_PUSH;
						end else begin
							fill_q  <= fill_inc;
							last_q  <= is_last;
							// encode once full, or drain after the last byte
							if (is_last || fill_inc == FW'(L)) begin
								state_q <= ST_START;
							end
						end
					end
				end
				ST_START: begin
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (!do_step && !tags_busy) begin
						state_q <= ST_SLIDE;
					end
				end
				ST_SLIDE: begin
					if (slide_q == best_q) begin
						fill_q <= fill_rem;
						if (last_q && fill_rem == '0) begin
							primed_q <= '0;
						end
						state_q <= ST_PUSH;
					end
				end
				ST_PUSH: begin
					if (out_free) begin
						if (!tok_lit_q && last_q && fill_q != '0) begin
							state_q <= ST_START;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers of the sequencer.
	always_ff @(posedge clk) begin
		if (accept && priming) begin
			tok_lit_q  <= 1'b1;
			tok_off_q  <= '0;
			tok_len_q  <= '0;
			tok_char_q <= data_byte;
			tok_fin_q  <= is_last;
		end
		if (state_q == ST_START) begin
			cap_q   <= LW'(fill_q - FW'(1));
			step_q  <= '0;
			best_q  <= '0;
			start_q <= '0;
			slide_q <= '0;
		end
		if (do_step) begin
			step_q <= step_q + LW'(1);
		end
		// flags only shrink, so the last step with a hit gives the longest match
		if (state_q == ST_CMP && tag_v_q[LG] && hit) begin
			best_q  <= tag_q[LG];
			start_q <= hit_idx;
		end
		if (state_q == ST_SLIDE) begin
			slide_q <= slide_q + LW'(1);
			if (slide_q == best_q) begin
				tok_lit_q  <= 1'b0;
				tok_off_q  <= (best_q == '0) ? '0 : OFF_W'(off_full);
				tok_len_q  <= LEN_W'(best_q);
				tok_char_q <= win_w[S];
				tok_fin_q  <= last_q && (fill_rem == '0);
			end
		end
	end

	// Output register: hold until taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_PUSH && out_free) begin
			out_valid_q <= 1'b1;
		end else if (token_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_PUSH && out_free) begin
			is_literal   <= tok_lit_q;
			match_offset <= tok_off_q;
			match_length <= tok_len_q;
			next_char    <= tok_char_q;
			final_token  <= tok_fin_q;
		end
	end

	assign token_valid = out_valid_q;

endmodule

>>> rtl/lz77te_checker.sv
// Port-level checks for the LZ77 triple encoder, bound to the top level.
`timescale 1ns / 1ps

module lz77te_checker import lz77te_pkg::*; #(
	parameter int SEARCH_SIZE    = 32,
	parameter int LOOKAHEAD_SIZE = 16
) (
	input logic             clk,
	input logic             arst_n,
	input logic             data_valid,
	input logic             data_ready,
	input logic             token_valid,
	input logic             token_ready,
	input logic             is_literal,
	input logic [OFF_W-1:0] match_offset,
	input logic [LEN_W-1:0] match_length,
	input logic [7:0]       next_char,
	input logic             final_token
);

	// a stalled token holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		token_valid && !token_ready |=> token_valid && $stable(is_literal)
			&& $stable(match_offset) && $stable(match_length)
			&& $stable(next_char) && $stable(final_token))
		else $error("token changed while stalled");

	a_lit: assert property (@(posedge clk) disable iff (!arst_n)
		token_valid && is_literal |-> match_offset == '0 && match_length == '0)
		else $error("literal carries a match");

	a_pair: assert property (@(posedge clk) disable iff (!arst_n)
		token_valid && !is_literal |-> (match_length == '0) == (match_offset == '0))
		else $error("offset and length disagree on a miss");

	a_len: assert property (@(posedge clk) disable iff (!arst_n)
		token_valid && !is_literal |->
			(LOOKAHEAD_SIZE > 16) || (32'(match_length) < LOOKAHEAD_SIZE))
		else $error("match length beyond lookahead");

	// hold a waiting byte request until the block takes it
	a_req: assert property (@(posedge clk) disable iff (!arst_n)
		data_valid && !data_ready |=> data_valid)
		else $error("request withdrawn");

endmodule

bind lz77_triple_encoder lz77te_checker #(
	.SEARCH_SIZE    (SEARCH_SIZE),
	.LOOKAHEAD_SIZE (LOOKAHEAD_SIZE)
) u_lz77te_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.data_valid   (data_valid),
	.data_ready   (data_ready),
	.token_valid  (token_valid),
	.token_ready  (token_ready),
	.is_literal   (is_literal),
	.match_offset (match_offset),
	.match_length (match_length),
	.next_char    (next_char),
	.final_token  (final_token)
);
